@@ rtl/fpa_pkg.sv @@
// fpa_pkg: shared types and constants of the fit placement allocator
// used by fpa_ctrl, fpa_datapath and fit_placement_allocator_core
package fpa_pkg;

	localparam int BLOCK_SLOTS = 16;
	localparam int SIZE_BITS   = 16;
	localparam int SLOT_W      = 4;   // load_index / chosen_block width
	localparam int CNT_W       = 5;   // block count, holds BLOCK_SLOTS itself
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 24;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	localparam logic CFG_FIT_MODE      = 1'b0;
	localparam logic CFG_BLOCKS_IN_USE = 1'b1;

	localparam logic [CNT_W-1:0] BLOCKS_RESET = CNT_W'(BLOCK_SLOTS);

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NEXT  = 2'd3
	} fit_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} fpa_state_t;

	typedef struct packed {
		logic start;   // latch the accepted item and set up the scan
		logic step;    // examine one table entry
		logic finish;  // write back and load the output register
	} fpa_cmd_t;

	typedef struct packed {
		logic is_request;
		logic count_zero;
		logic scan_last;
		logic hit_stop;
		logic out_free;
	} fpa_stat_t;

endpackage

@@ rtl/fit_placement_allocator_core.sv @@
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser kind; tdata load_index, amount
// m_*       out  m_tvalid/m_tready  tuser granted; tdata chosen_block, left_over
// cfg_*     in   cfg_we             cfg_index selects fit_mode or blocks_in_use
//
// a request is accepted, scans the table entries (up to 16, fewer when first or next
// fit hits early, none when no block is in use) and is written back
// a load is accepted and written back with no scan; the scan reads one entry per cycle
// reset clears the table, next fit pointer and output valid flag at once
// a result waits in the output register; the next item is taken meanwhile and
// stalls only in write-back until the register frees
//
// top level of the allocator: fpa_ctrl sequencer and fpa_datapath
// depends on fpa_pkg, fpa_ctrl, fpa_datapath
module fit_placement_allocator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fpa_pkg::IN_DATA_W-1:0]  s_tdata,   // load_index[3:0], amount[19:4]
	input  logic                           s_tuser,   // kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fpa_pkg::OUT_DATA_W-1:0] m_tdata,   // chosen_block[3:0], left_over[19:4]
	output logic                           m_tuser,   // granted
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [fpa_pkg::CNT_W-1:0]      cfg_data
);
	import fpa_pkg::*;

	fpa_cmd_t  cmd;
	fpa_stat_t stat;

	fpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	fpa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

@@ rtl/fpa_ctrl.sv @@
// fpa_ctrl: sequencer of the allocator, one item at a time
// depends on fpa_pkg; drives fpa_datapath through fpa_cmd_t
module fpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  fpa_pkg::fpa_stat_t stat,
	output logic              s_tready,
	output fpa_pkg::fpa_cmd_t  cmd
);
	import fpa_pkg::*;

	fpa_state_t state_q;
	fpa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (!stat.is_request || stat.count_zero) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (stat.scan_last || stat.hit_stop) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.start = s_tvalid;
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.start && cmd.step) && !(cmd.step && cmd.finish))
	else $error("fpa_ctrl: overlapping commands");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == ST_IDLE)
	else $error("fpa_ctrl: no return to idle after finish");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !stat.scan_last && !stat.hit_stop) |=> state_q == ST_SCAN)
	else $error("fpa_ctrl: scan left early");

endmodule

@@ rtl/fpa_datapath.sv @@
// fpa_datapath: free size table, config registers, scan unit and output register
// depends on fpa_pkg; commanded by fpa_ctrl
module fpa_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fpa_pkg::fpa_cmd_t              cmd,
	output fpa_pkg::fpa_stat_t             stat,
	input  logic [fpa_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fpa_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tuser,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [fpa_pkg::CNT_W-1:0]      cfg_data
);
	import fpa_pkg::*;

	logic [SIZE_BITS-1:0] free_q [BLOCK_SLOTS];
	logic [SLOT_W-1:0]    next_start_q;
	fit_mode_t            fit_mode_q;
	logic [CNT_W-1:0]     blocks_q;

	logic                 kind_q;
	logic [SLOT_W-1:0]    load_idx_q;
	logic [SIZE_BITS-1:0] amount_q;
	logic [CNT_W-1:0]     count_q;
	logic [SLOT_W-1:0]    idx_q;
	logic [SLOT_W-1:0]    step_q;
	logic                 found_q;
	logic [SLOT_W-1:0]    best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;

	logic                 out_valid_q;
	logic                 out_granted_q;
	logic [SLOT_W-1:0]    out_block_q;
	logic [SIZE_BITS-1:0] out_left_q;

	logic [CNT_W-1:0]     active_cnt;
	logic [SLOT_W-1:0]    start_idx;
	logic [SIZE_BITS-1:0] rd_size;
	logic                 fits;
	logic                 better;
	logic                 out_free;
	logic                 load_in_range;
	logic [SIZE_BITS-1:0] remain;

	assign active_cnt = (blocks_q > CNT_W'(BLOCK_SLOTS)) ? CNT_W'(BLOCK_SLOTS) : blocks_q;
	// next fit resumes at the last granted block unless it fell outside the count
	assign start_idx  = (fit_mode_q == FIT_NEXT && {1'b0, next_start_q} < active_cnt)
		? next_start_q : '0;

	assign rd_size = free_q[idx_q];
	assign fits    = rd_size >= amount_q;
	assign better  = !found_q
		|| (fit_mode_q == FIT_BEST  && rd_size < best_size_q)
		|| (fit_mode_q == FIT_WORST && rd_size > best_size_q);

	assign out_free      = !out_valid_q || m_tready;
	assign load_in_range = {1'b0, load_idx_q} < CNT_W'(BLOCK_SLOTS);
	assign remain        = best_size_q - amount_q;

	assign stat.is_request = (s_tuser == KIND_REQUEST);
	assign stat.count_zero = (active_cnt == '0);
	assign stat.scan_last  = ({1'b0, step_q} == count_q - CNT_W'(1));
	assign stat.hit_stop   = fits && (fit_mode_q == FIT_FIRST || fit_mode_q == FIT_NEXT);
	assign stat.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_FIRST;
			blocks_q   <= BLOCKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIT_MODE:      fit_mode_q <= fit_mode_t'(cfg_data[1:0]);
				CFG_BLOCKS_IN_USE: blocks_q   <= cfg_data;
				default:           blocks_q   <= blocks_q;
			endcase
		end
	end

	// item registers and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			count_q <= '0;
			step_q  <= '0;
			idx_q   <= '0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
			count_q <= active_cnt;
			step_q  <= '0;
			idx_q   <= start_idx;
		end else if (cmd.step) begin
			if (fits && better) begin
				found_q <= 1'b1;
			end
			step_q <= step_q + SLOT_W'(1);
			if ({1'b0, idx_q} == count_q - CNT_W'(1)) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q     <= s_tuser;
			load_idx_q <= s_tdata[SLOT_W-1:0];
			amount_q   <= s_tdata[SLOT_W +: SIZE_BITS];
		end
		if (cmd.step && fits && better) begin
			best_idx_q  <= idx_q;
			best_size_q <= rd_size;
		end
	end

	// table write-back and next fit pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BLOCK_SLOTS; i++) begin
				free_q[i] <= '0;
			end
			next_start_q <= '0;
		end else if (cmd.finish) begin
			if (kind_q == KIND_LOAD) begin
				if (load_in_range) begin
					free_q[load_idx_q] <= amount_q;
				end
				next_start_q <= '0;
			end else if (found_q) begin
				free_q[best_idx_q] <= remain;
				if (fit_mode_q == FIT_NEXT) begin
					next_start_q <= best_idx_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (kind_q == KIND_LOAD) begin
				out_granted_q <= 1'b0;
				out_block_q   <= load_idx_q;
				out_left_q    <= load_in_range ? amount_q : '0;
			end else if (found_q) begin
				out_granted_q <= 1'b1;
				out_block_q   <= best_idx_q;
				out_left_q    <= remain;
			end else begin
				out_granted_q <= 1'b0;
				out_block_q   <= '0;
				out_left_q    <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_granted_q;
	assign m_tdata  = {(OUT_DATA_W - SLOT_W - SIZE_BITS)'(0), out_left_q, out_block_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> ({1'b0, idx_q} < count_q && {1'b0, step_q} < count_q))
	else $error("fpa_datapath: scan ran past the active count");

	assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_size_q >= amount_q && {1'b0, best_idx_q} < count_q))
	else $error("fpa_datapath: recorded block does not fit");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && kind_q == KIND_REQUEST && found_q) |=> (m_tuser && m_tvalid))
	else $error("fpa_datapath: grant lost on the way out");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for fit_placement_allocator_core, loads and placement requests
// in all four fit modes, with a directed table, random phases, idle gaps on the input and back-pressure on the output
// depends on fpa_pkg and the allocator rtl
module tb_top;
	import fpa_pkg::*;

	typedef struct packed {
		logic        granted;
		logic [3:0]  block;
		logic [15:0] left;
	} alloc_result_t;

	typedef enum {ROW_ITEM, ROW_CFG} row_op_t;

	typedef struct {
		row_op_t       op;
		logic          kind;
		logic [3:0]    idx;
		logic [15:0]   amt;
		bit            typed;
		alloc_result_t res;
		logic          sel;
		logic [4:0]    val;
	} stim_row_t;

	localparam int DIR_ROWS   = 30;
	localparam int PHASES     = 18;
	localparam int PHASE_LEN  = 92;
	localparam int LONG_HOLD  = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // load_index[3:0], amount[19:4]
	logic                  s_tuser;   // kind
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // chosen_block[3:0], left_over[19:4]
	logic                  m_tuser;   // granted
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CNT_W-1:0]      cfg_data;

	// allocator model state
	logic [15:0]      free_sz [BLOCK_SLOTS];
	int               next_ptr;
	fit_mode_t        mode_r;
	logic [CNT_W-1:0] blocks_r;

	alloc_result_t expected_q [$];
	stim_row_t     dir_rows [DIR_ROWS];
	int            fail_count;
	bit            idle_on;
	int            hold_asks;
	int            hold_done;

	fit_placement_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic alloc_result_t place_item(input logic k, input logic [3:0] idx,
		input logic [15:0] amt);
		alloc_result_t r;
		int cnt;
		int start;
		int pos;
		int pick;
		bit found;
		r = '0;
		pick = 0;
		found = 0;
		cnt = (int'(blocks_r) > BLOCK_SLOTS) ? BLOCK_SLOTS : int'(blocks_r);
		if (k == KIND_LOAD) begin
			free_sz[idx] = amt;
			next_ptr = 0;
			r.block = idx;
			r.left = amt;
			return r;
		end
		if (mode_r == FIT_NEXT) begin
			// circular scan, the last granted block is looked at first unless it lies outside the count
			start = (next_ptr < cnt) ? next_ptr : 0;
			for (int j = 0; j < cnt && !found; j++) begin
				pos = (start + j) % cnt;
				if (free_sz[pos] >= amt) begin
					found = 1;
					pick = pos;
				end
			end
		end else begin
			for (int j = 0; j < cnt; j++) begin
				if (free_sz[j] >= amt && !(found && mode_r == FIT_FIRST)) begin
					if (!found || (mode_r == FIT_BEST && free_sz[j] < free_sz[pick]) ||
						(mode_r == FIT_WORST && free_sz[j] > free_sz[pick])) begin
						pick = j;
						found = 1;
					end
				end
			end
		end
		if (found) begin
			free_sz[pick] = free_sz[pick] - amt;
			if (mode_r == FIT_NEXT)
				next_ptr = pick;
			r.granted = 1'b1;
			r.block = 4'(pick);
			r.left = free_sz[pick];
		end
		return r;
	endfunction

	function automatic stim_row_t row_item(input logic k, input logic [3:0] idx,
		input logic [15:0] amt);
		stim_row_t r;
		r = '{op: ROW_ITEM, kind: k, idx: idx, amt: amt, typed: 0, res: '0, sel: 1'b0, val: '0};
		return r;
	endfunction

	function automatic stim_row_t row_typed(input logic k, input logic [3:0] idx,
		input logic [15:0] amt, input logic g, input logic [3:0] b, input logic [15:0] l);
		stim_row_t r;
		r = row_item(k, idx, amt);
		r.typed = 1;
		r.res = '{granted: g, block: b, left: l};
		return r;
	endfunction

	function automatic stim_row_t row_cfg(input logic sel, input logic [4:0] val);
		stim_row_t r;
		r = row_item(KIND_LOAD, 4'd0, 16'd0);
		r.op = ROW_CFG;
		r.sel = sel;
		r.val = val;
		return r;
	endfunction

	task automatic send_item(input logic k, input logic [3:0] idx, input logic [15:0] amt,
		input bit typed, input alloc_result_t typed_res);
		alloc_result_t model_res;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= IN_DATA_W'({amt, idx});
		do @(posedge clk); while (!s_tready);
		model_res = place_item(k, idx, amt);
		expected_q.push_back(typed ? typed_res : model_res);
	endtask

	// registers change only with nothing in flight
	task automatic write_reg(input logic sel, input logic [4:0] val);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		if (sel == CFG_FIT_MODE)
			mode_r = fit_mode_t'(val[1:0]);
		else
			blocks_r = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] load_amount();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(1, 4000));
		endcase
	endfunction

	function automatic logic [15:0] request_amount();
		int j;
		j = $urandom_range(0, BLOCK_SLOTS - 1);
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: begin
				// sized against a random table entry so most requests can land somewhere
				if (free_sz[j] == 16'd0)
					return 16'($urandom_range(0, 50));
				return 16'($urandom_range(0, int'(free_sz[j])));
			end
		endcase
	endfunction

	// receiver: random stalls plus one long hold that backs the block up
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		m_tready = 1'b0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_done < hold_asks) begin
				hold_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("result with no item pending: granted %0d chosen_block %0d left_over %0d",
					m_tuser, m_tdata[3:0], m_tdata[19:4]);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (m_tuser !== want.granted) begin
					$error("granted: expected %0d, got %0d", want.granted, m_tuser);
					fail_count++;
				end
				if (m_tdata[3:0] !== want.block) begin
					$error("chosen_block: expected %0d, got %0d", want.block, m_tdata[3:0]);
					fail_count++;
				end
				if (m_tdata[19:4] !== want.left) begin
					$error("left_over: expected %0d, got %0d", want.left, m_tdata[19:4]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#8000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic k;
		int waited;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		fail_count = 0;
		idle_on = 1;
		hold_asks = 0;
		foreach (free_sz[i]) free_sz[i] = 16'd0;
		next_ptr = 0;
		mode_r = FIT_FIRST;
		blocks_r = BLOCKS_RESET;

		dir_rows = '{
			row_typed(KIND_REQUEST, 4'd0, 16'd0, 1'b1, 4'd0, 16'd0),  // zero fits empty block
			row_typed(KIND_REQUEST, 4'd0, 16'd1, 1'b0, 4'd0, 16'd0),  // nothing fits
			row_typed(KIND_LOAD, 4'd0, 16'hFFFF, 1'b0, 4'd0, 16'hFFFF),
			row_typed(KIND_LOAD, 4'd15, 16'd100, 1'b0, 4'd15, 16'd100),
			row_typed(KIND_LOAD, 4'd5, 16'd300, 1'b0, 4'd5, 16'd300),
			row_typed(KIND_LOAD, 4'd7, 16'd50, 1'b0, 4'd7, 16'd50),
			row_typed(KIND_REQUEST, 4'd9, 16'hFFFF, 1'b1, 4'd0, 16'd0),
			row_item(KIND_REQUEST, 4'd0, 16'd60),
			row_cfg(CFG_FIT_MODE, 5'(FIT_BEST)),
			row_item(KIND_REQUEST, 4'd0, 16'd40),
			row_item(KIND_LOAD, 4'd3, 16'd240),
			row_item(KIND_REQUEST, 4'd0, 16'd200),                    // tie on size
			row_cfg(CFG_FIT_MODE, 5'(FIT_WORST)),
			row_item(KIND_REQUEST, 4'd0, 16'd10),
			row_cfg(CFG_FIT_MODE, 5'(FIT_NEXT)),
			row_item(KIND_REQUEST, 4'd0, 16'd5),
			row_item(KIND_REQUEST, 4'd0, 16'd5),                      // same block again
			row_item(KIND_REQUEST, 4'd0, 16'd90),
			row_item(KIND_REQUEST, 4'd0, 16'd100),
			row_item(KIND_REQUEST, 4'd0, 16'd100),                    // walks up to block 15
			row_cfg(CFG_BLOCKS_IN_USE, 5'd4),
			row_item(KIND_REQUEST, 4'd0, 16'd10),                     // pointer past the count
			row_cfg(CFG_BLOCKS_IN_USE, 5'd0),
			row_typed(KIND_REQUEST, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0),
			row_cfg(CFG_BLOCKS_IN_USE, 5'd31),
			row_item(KIND_REQUEST, 4'd0, 16'd0),
			row_cfg(CFG_BLOCKS_IN_USE, 5'd1),
			row_typed(KIND_REQUEST, 4'd0, 16'd1, 1'b0, 4'd0, 16'd0),
			row_cfg(CFG_BLOCKS_IN_USE, 5'd16),
			row_cfg(CFG_FIT_MODE, 5'(FIT_FIRST))
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].op == ROW_CFG)
				write_reg(dir_rows[i].sel, dir_rows[i].val);
			else
				send_item(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].amt,
					dir_rows[i].typed, dir_rows[i].res);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(CFG_FIT_MODE, 5'($urandom_range(0, 3)));
			case ($urandom_range(0, 9))
				0: write_reg(CFG_BLOCKS_IN_USE, 5'd0);
				1: write_reg(CFG_BLOCKS_IN_USE, 5'($urandom_range(17, 31)));
				2: write_reg(CFG_BLOCKS_IN_USE, 5'd16);
				3: write_reg(CFG_BLOCKS_IN_USE, 5'd1);
				default: write_reg(CFG_BLOCKS_IN_USE, 5'($urandom_range(1, 16)));
			endcase
			if (ph == PHASES / 2)
				hold_asks++;
			if (ph == PHASES - 1)
				idle_on = 0;
			for (int n = 0; n < PHASE_LEN; n++) begin
				k = ($urandom_range(0, 9) < 3) ? KIND_LOAD : KIND_REQUEST;
				if (k == KIND_LOAD)
					send_item(k, 4'($urandom), load_amount(), 0, '0);
				else
					send_item(k, 4'($urandom), request_amount(), 0, '0);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		for (waited = 0; waited < 5000 && expected_q.size() != 0; waited++)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d results never arrived", expected_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
